FILE: rtl/ncm_pkg.sv
// ----------------------------------------------------------------------------
// ncm_pkg
// Shared types, codes and constants of the nearest centroid cosine match block.
// ----------------------------------------------------------------------------
package ncm_pkg;

	// Fixed field widths
	localparam int VALUE_BITS    = 16;
	localparam int SIM_BITS      = 41;
	localparam int ID_BITS       = 31;
	localparam int CFG_DATA_BITS = 41;
	localparam int CFG_IDX_BITS  = 2;

	// Parameter defaults
	localparam int MAX_ENTRIES_DEF = 256;
	localparam int VECTOR_LEN_DEF  = 512;

	// Input operation codes
	localparam logic [1:0] OP_CEN_WR = 2'd0;
	localparam logic [1:0] OP_ID_WR  = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ENTRY_COUNT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_IN_USE  = 2'd2;

	// Register reset values
	localparam logic signed [SIM_BITS-1:0] THRESHOLD_RST   = 41'sd536870912;
	localparam logic [8:0]                 ENTRY_COUNT_RST = 9'd0;
	localparam logic [9:0]                 DIM_IN_USE_RST  = 10'd128;

	// Similarity of -1.0 in Q scaled by 2^30
	localparam logic signed [SIM_BITS-1:0] MINUS_ONE_SCALED = -41'sd1073741824;

	// Best entry of a finished search
	typedef struct packed {
		logic [SIM_BITS-1:0] score;
		logic [ID_BITS-1:0]  id;
	} result_t;

	// Search engine status toward the top level
	typedef struct packed {
		logic busy;
		logic done;
	} srch_stat_t;

	// Address bits for a store of n entries
	function automatic int addr_bits(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

FILE: rtl/nearest_centroid_cosine_match.sv
// ----------------------------------------------------------------------------
// nearest_centroid_cosine_match
// Write, identifier and non-final query words are taken while no search is busy.
// A final query word starts a search over n_entries entries of dim_in_use
// elements, one element pair read per cycle, with no reads when there are no
// entries; the pipeline then drains before the result is handed over. No word is
// taken until the result is handed over to the output register. Reset clears
// the control state and loads the register defaults; memories are unset.
// ----------------------------------------------------------------------------
module nearest_centroid_cosine_match #(
	parameter int MAX_ENTRIES = ncm_pkg::MAX_ENTRIES_DEF,
	parameter int VECTOR_LEN  = ncm_pkg::VECTOR_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ncm_pkg::CFG_IDX_BITS-1:0]      cfg_idx,
	input  logic [ncm_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            op,
	input  logic [7:0]                            entry,
	input  logic [8:0]                            element,
	input  logic signed [ncm_pkg::VALUE_BITS-1:0] value,
	input  logic [ncm_pkg::ID_BITS-1:0]           face_id,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  matched,
	output logic                                  any_entry,
	output logic [ncm_pkg::ID_BITS-1:0]           best_id,
	output logic signed [ncm_pkg::SIM_BITS-1:0]   similarity
);

	localparam int EW  = ncm_pkg::addr_bits(MAX_ENTRIES);
	localparam int IW  = ncm_pkg::addr_bits(VECTOR_LEN);
	localparam int CAW = ncm_pkg::addr_bits(MAX_ENTRIES * VECTOR_LEN);
	localparam int NW  = $clog2(MAX_ENTRIES + 1);
	localparam int VB  = ncm_pkg::VALUE_BITS;
	localparam int SW  = ncm_pkg::SIM_BITS;

	logic signed [SW-1:0] threshold_q;
	logic [8:0]           entry_count_q;
	logic [9:0]           dim_in_use_q;

	logic                 in_fire;
	logic                 entry_ok;
	logic                 elem_ok;
	logic [31:0]          dim_w;
	logic [31:0]          last_w;
	logic [NW-1:0]        n_entries;
	logic [IW-1:0]        last_idx;
	logic                 trigger;
	logic                 cen_we, id_we, qry_we;
	logic [CAW-1:0]       cen_waddr;

	logic                 rd_en;
	logic [IW-1:0]        qry_raddr;
	logic [CAW-1:0]       cen_raddr;
	logic [EW-1:0]        id_raddr;
	logic [VB-1:0]        qry_rdata;
	logic [VB-1:0]        cen_rdata;
	logic [ncm_pkg::ID_BITS-1:0] id_rdata;

	ncm_pkg::result_t     res;
	ncm_pkg::srch_stat_t  stat;
	logic                 res_free;

	logic                 out_valid_q;
	logic                 matched_q;
	logic                 any_q;
	logic [ncm_pkg::ID_BITS-1:0] best_id_q;
	logic [SW-1:0]        sim_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= ncm_pkg::THRESHOLD_RST;
			entry_count_q <= ncm_pkg::ENTRY_COUNT_RST;
			dim_in_use_q  <= ncm_pkg::DIM_IN_USE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				ncm_pkg::CFG_THRESHOLD:   threshold_q   <= $signed(cfg_data[SW-1:0]);
				ncm_pkg::CFG_ENTRY_COUNT: entry_count_q <= cfg_data[8:0];
				ncm_pkg::CFG_DIM_IN_USE:  dim_in_use_q  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Clamp the searched entry count and vector length
	always_comb begin
		if (32'(entry_count_q) > 32'(MAX_ENTRIES)) begin
			n_entries = NW'(MAX_ENTRIES);
		end else begin
			n_entries = NW'(entry_count_q);
		end
		dim_w = 32'(dim_in_use_q);
		if (dim_w == 32'd0) begin
			dim_w = 32'd1;
		end else if (dim_w > 32'(VECTOR_LEN)) begin
			dim_w = 32'(VECTOR_LEN);
		end
		last_w   = dim_w - 32'd1;
		last_idx = IW'(last_w);
	end

	// Decode the input word; hold input while a search runs
	assign in_ready  = !stat.busy;
	assign in_fire   = in_valid && in_ready;
	assign entry_ok  = (32'(entry) < 32'(MAX_ENTRIES));
	assign elem_ok   = (32'(element) < 32'(VECTOR_LEN));
	assign cen_we    = in_fire && (op == ncm_pkg::OP_CEN_WR) && entry_ok && elem_ok;
	assign id_we     = in_fire && (op == ncm_pkg::OP_ID_WR) && entry_ok;
	assign qry_we    = in_fire && (op == ncm_pkg::OP_QUERY) && elem_ok;
	assign trigger   = qry_we && (32'(element) == last_w);
	assign cen_waddr = CAW'(32'(entry) * 32'(VECTOR_LEN) + 32'(element));

	ncm_ram #(.WIDTH(VB), .DEPTH(MAX_ENTRIES * VECTOR_LEN)) u_cen_ram (
		.clk   (clk),
		.we    (cen_we),
		.waddr (cen_waddr),
		.wdata (value),
		.re    (rd_en),
		.raddr (cen_raddr),
		.rdata (cen_rdata)
	);

	ncm_ram #(.WIDTH(ncm_pkg::ID_BITS), .DEPTH(MAX_ENTRIES)) u_id_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (EW'(entry)),
		.wdata (face_id),
		.re    (rd_en),
		.raddr (id_raddr),
		.rdata (id_rdata)
	);

	ncm_ram #(.WIDTH(VB), .DEPTH(VECTOR_LEN)) u_qry_ram (
		.clk   (clk),
		.we    (qry_we),
		.waddr (IW'(element)),
		.wdata (value),
		.re    (rd_en),
		.raddr (qry_raddr),
		.rdata (qry_rdata)
	);

	ncm_search #(.MAX_ENTRIES(MAX_ENTRIES), .VECTOR_LEN(VECTOR_LEN)) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (trigger),
		.n_entries (n_entries),
		.last_idx  (last_idx),
		.res_free  (res_free),
		.rd_en     (rd_en),
		.qry_raddr (qry_raddr),
		.cen_raddr (cen_raddr),
		.id_raddr  (id_raddr),
		.qry_rdata (qry_rdata),
		.cen_rdata (cen_rdata),
		.id_rdata  (id_rdata),
		.res       (res),
		.stat      (stat)
	);

	// Output register: load a finished search, drop when taken
	assign res_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			matched_q <= ($signed(res.score) >= threshold_q);
			any_q     <= ($signed(res.score) > ncm_pkg::MINUS_ONE_SCALED);
			best_id_q <= res.id;
			sim_q     <= res.score;
		end
	end

	assign out_valid  = out_valid_q;
	assign matched    = matched_q;
	assign any_entry  = any_q;
	assign best_id    = best_id_q;
	assign similarity = $signed(sim_q);

	// A search never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (!out_valid_q || out_ready))
		else $error("search result overwrote a pending word");

	// A final query word always starts a search
	a_trigger_busy: assert property (@(posedge clk) disable iff (!arst_n)
		trigger |=> stat.busy)
		else $error("final query word did not start a search");

	// With no winning entry the identifier is zero and similarity is -1.0
	a_no_winner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !any_q) |->
			(best_id_q == '0 && $signed(sim_q) == ncm_pkg::MINUS_ONE_SCALED))
		else $error("no-winner result carries a stale entry");

endmodule

FILE: rtl/ncm_ram.sv
// ----------------------------------------------------------------------------
// ncm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ncm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [ncm_pkg::addr_bits(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [ncm_pkg::addr_bits(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/ncm_search.sv
// ----------------------------------------------------------------------------
// ncm_search
// Search sequencer and multiply-accumulate pipeline: walks each element in use of
// every searched entry, accumulates exact dot products and keeps the best.
// ----------------------------------------------------------------------------
module ncm_search #(
	parameter int MAX_ENTRIES = ncm_pkg::MAX_ENTRIES_DEF,
	parameter int VECTOR_LEN  = ncm_pkg::VECTOR_LEN_DEF,
	localparam int EW  = ncm_pkg::addr_bits(MAX_ENTRIES),
	localparam int IW  = ncm_pkg::addr_bits(VECTOR_LEN),
	localparam int CAW = ncm_pkg::addr_bits(MAX_ENTRIES * VECTOR_LEN),
	localparam int NW  = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [NW-1:0]                   n_entries,
	input  logic [IW-1:0]                   last_idx,
	input  logic                            res_free,
	output logic                            rd_en,
	output logic [IW-1:0]                   qry_raddr,
	output logic [CAW-1:0]                  cen_raddr,
	output logic [EW-1:0]                   id_raddr,
	input  logic [ncm_pkg::VALUE_BITS-1:0]  qry_rdata,
	input  logic [ncm_pkg::VALUE_BITS-1:0]  cen_rdata,
	input  logic [ncm_pkg::ID_BITS-1:0]     id_rdata,
	output ncm_pkg::result_t                res,
	output ncm_pkg::srch_stat_t             stat
);

	localparam int PW = 2 * ncm_pkg::VALUE_BITS;
	localparam int SW = ncm_pkg::SIM_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t          state_q;
	logic [EW-1:0]   ent_q;
	logic [IW-1:0]   elem_q;
	logic [CAW-1:0]  base_q;
	logic [NW-1:0]   n_q;
	logic [IW-1:0]   last_q;

	logic            v_s1, last_s1;
	logic            v_s2, last_s2;
	logic signed [PW-1:0]  prod_s2;
	logic [ncm_pkg::ID_BITS-1:0] id_s2;
	logic            v_s3;
	logic [SW-1:0]   dot_s3;
	logic [ncm_pkg::ID_BITS-1:0] id_s3;
	logic [SW-1:0]   acc_q;
	logic [SW-1:0]   best_q;
	logic [ncm_pkg::ID_BITS-1:0] bid_q;

	logic            issue;
	logic            elem_last;
	logic            ent_last;
	logic [SW-1:0]   sum;

	assign issue     = (state_q == ST_RUN);
	assign elem_last = (elem_q == last_q);
	assign ent_last  = ((NW'(ent_q) + NW'(1)) == n_q);

	// Read addresses of the current element
	assign rd_en     = issue;
	assign qry_raddr = elem_q;
	assign cen_raddr = base_q + CAW'(elem_q);
	assign id_raddr  = ent_q;

	// Sequencer: walk elements, then entries, then drain and hand over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ent_q   <= '0;
			elem_q  <= '0;
			base_q  <= '0;
			n_q     <= '0;
			last_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						ent_q   <= '0;
						elem_q  <= '0;
						base_q  <= '0;
						n_q     <= n_entries;
						last_q  <= last_idx;
						state_q <= (n_entries == '0) ? ST_FINISH : ST_RUN;
					end
				end
				ST_RUN: begin
					if (elem_last) begin
						elem_q <= '0;
						base_q <= base_q + CAW'(VECTOR_LEN);
						ent_q  <= ent_q + EW'(1);
						if (ent_last) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						elem_q <= elem_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Pipeline valid and last flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			v_s1    <= issue;
			last_s1 <= issue && elem_last;
			v_s2    <= v_s1;
			last_s2 <= v_s1 && last_s1;
			v_s3    <= v_s2 && last_s2;
		end
	end

	// Multiply the element pair once the memories answer
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= $signed(qry_rdata) * $signed(cen_rdata);
			id_s2   <= id_rdata;
		end
	end

	assign sum = acc_q + SW'(prod_s2);

	// Accumulate modulo 2^41; close the dot product on an entry's last element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (start && state_q == ST_IDLE) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= last_s2 ? '0 : sum;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && last_s2) begin
			dot_s3 <= sum;
			id_s3  <= id_s2;
		end
	end

	// Keep the first strictly greatest similarity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= ncm_pkg::MINUS_ONE_SCALED;
			bid_q  <= '0;
		end else if (start && state_q == ST_IDLE) begin
			best_q <= ncm_pkg::MINUS_ONE_SCALED;
			bid_q  <= '0;
		end else if (v_s3 && ($signed(dot_s3) > $signed(best_q))) begin
			best_q <= dot_s3;
			bid_q  <= id_s3;
		end
	end

	assign res.score = best_q;
	assign res.id    = bid_q;
	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_FINISH) && res_free;

	// Pipeline words exist only while a search runs or drains
	a_s1_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("element word in flight outside a search");

	// The result is handed over only with an empty pipeline
	a_finish_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("search finished with words in flight");

endmodule

FILE: sim/tb_nearest_centroid_cosine_match.sv
// ----------------------------------------------------------------------------
// tb_nearest_centroid_cosine_match
// Self-checking bench for the centroid search block. A scoreboard keeps its
// own copy of the centroid, identifier and query memories and of the three
// registers. On every final query word it runs the full dot-product search
// and queues the expected best match. Returned results are compared in order.
// Stimulus starts with directed words for the value extremes, ties, the empty
// database and the minus-one floor. It then runs random phases that change
// the registers, load the database and send query sequences with noise
// words mixed in, under several handshake idle profiles.
// ----------------------------------------------------------------------------
module tb_nearest_centroid_cosine_match;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_BITS    = ncm_pkg::VALUE_BITS;
	localparam int SIM_BITS      = ncm_pkg::SIM_BITS;
	localparam int ID_BITS       = ncm_pkg::ID_BITS;
	localparam int CFG_IDX_BITS  = ncm_pkg::CFG_IDX_BITS;
	localparam int CFG_DATA_BITS = ncm_pkg::CFG_DATA_BITS;
	localparam int PROD_BITS     = 2 * VALUE_BITS;

	localparam int N_ENT             = ncm_pkg::MAX_ENTRIES_DEF;
	localparam int N_ELEM            = ncm_pkg::VECTOR_LEN_DEF;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam int RANDOM_WORDS      = 200;
	localparam int QUERIES_PER_PHASE = 6;
	localparam int SETTLE_CYCLES     = 10;
	localparam int CYCLE_LIMIT       = 2_000_000;

	localparam logic signed [VALUE_BITS-1:0] VAL_MAX  = 16'sh7fff;
	localparam logic signed [VALUE_BITS-1:0] VAL_MIN  = 16'sh8000;
	localparam logic signed [VALUE_BITS-1:0] VAL_HALF = 16'sh4000;
	localparam logic [ID_BITS-1:0]           ID_MAX   = '1;
	localparam logic signed [SIM_BITS-1:0]   THR_MIN  = {1'b1, {(SIM_BITS-1){1'b0}}};
	localparam logic signed [SIM_BITS-1:0]   THR_MAX  = {1'b0, {(SIM_BITS-1){1'b1}}};

	typedef struct {
		bit                       matched;
		bit                       any_entry;
		bit [ID_BITS-1:0]         best_id;
		bit signed [SIM_BITS-1:0] similarity;
	} match_t;

	// Scoreboard: mirror of the block's memories and registers
	class match_tracker;
		bit signed [VALUE_BITS-1:0] centroids [N_ENT*N_ELEM];
		bit [ID_BITS-1:0]           face_ids [N_ENT];
		bit signed [VALUE_BITS-1:0] query [N_ELEM];
		bit signed [SIM_BITS-1:0]   threshold;
		bit [8:0]                   entry_count;
		bit [9:0]                   dim_reg;
		match_t                     awaited [$];
		int                         errors;

		function new();
			threshold   = ncm_pkg::THRESHOLD_RST;
			entry_count = ncm_pkg::ENTRY_COUNT_RST;
			dim_reg     = ncm_pkg::DIM_IN_USE_RST;
			errors      = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				ncm_pkg::CFG_THRESHOLD:   threshold = data;
				ncm_pkg::CFG_ENTRY_COUNT: entry_count = data[8:0];
				ncm_pkg::CFG_DIM_IN_USE:  dim_reg = data[9:0];
				default: ;
			endcase
		endfunction

		// Clamp the vector length into 1..N_ELEM
		function int search_dim();
			if (dim_reg == 0)
				return 1;
			if (dim_reg > N_ELEM)
				return N_ELEM;
			return int'(dim_reg);
		endfunction

		function int search_entries();
			return (entry_count > N_ENT) ? N_ENT : int'(entry_count);
		endfunction

		// Exact dot product per entry; keep the first strictly greater score
		function match_t best_match();
			match_t                         r;
			bit signed [SIM_BITS-1:0]       acc;
			bit signed [SIM_BITS-1:0]       best;
			bit signed [PROD_BITS-1:0]      prod;
			bit [ID_BITS-1:0]               best_face;
			int                             n;
			int                             dim;
			n = search_entries();
			dim = search_dim();
			best = ncm_pkg::MINUS_ONE_SCALED;
			best_face = '0;
			for (int e = 0; e < n; e++) begin
				acc = '0;
				for (int i = 0; i < dim; i++) begin
					prod = PROD_BITS'(query[i]) * PROD_BITS'(centroids[e*N_ELEM + i]);
					acc += SIM_BITS'(prod);
				end
				if (acc > best) begin
					best = acc;
					best_face = face_ids[e];
				end
			end
			r.matched = (best >= threshold);
			r.any_entry = (best > ncm_pkg::MINUS_ONE_SCALED);
			r.best_id = best_face;
			r.similarity = best;
			return r;
		endfunction

		function void note_word(logic [1:0] w_op, logic [7:0] ent, logic [8:0] elem,
				logic signed [VALUE_BITS-1:0] val, logic [ID_BITS-1:0] fid);
			case (w_op)
				ncm_pkg::OP_CEN_WR: centroids[int'(ent)*N_ELEM + int'(elem)] = val;
				ncm_pkg::OP_ID_WR:  face_ids[ent] = fid;
				ncm_pkg::OP_QUERY: begin
					query[elem] = val;
					if (int'(elem) == search_dim() - 1)
						awaited = {awaited, best_match()};
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic m, logic a, logic [ID_BITS-1:0] id,
				logic signed [SIM_BITS-1:0] sim);
			match_t w;
			if (awaited.size() == 0) begin
				$error("result with no search pending: best_id %0d similarity %0d", id, sim);
				errors++;
				return;
			end
			w = awaited.pop_front();
			if (m !== w.matched) begin
				$error("matched: expected %0d, got %0d", w.matched, m);
				errors++;
			end
			if (a !== w.any_entry) begin
				$error("any_entry: expected %0d, got %0d", w.any_entry, a);
				errors++;
			end
			if (id !== w.best_id) begin
				$error("best_id: expected %0d, got %0d", w.best_id, id);
				errors++;
			end
			if (sim !== w.similarity) begin
				$error("similarity: expected %0d, got %0d", w.similarity, sim);
				errors++;
			end
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]      cfg_idx = '0;
	logic [CFG_DATA_BITS-1:0]     cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [1:0]                   op = '0;
	logic [7:0]                   entry = '0;
	logic [8:0]                   element = '0;
	logic signed [VALUE_BITS-1:0] value = '0;
	logic [ID_BITS-1:0]           face_id = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic                         matched;
	logic                         any_entry;
	logic [ID_BITS-1:0]           best_id;
	logic signed [SIM_BITS-1:0]   similarity;

	match_tracker tracker = new;

	// Cells written so far; a search never reads one that is still unset
	bit cen_set [N_ENT][N_ELEM];
	bit id_set [N_ENT];
	bit qry_set [N_ELEM];

	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int scored_words = 0;
	int cycle_cnt = 0;

	nearest_centroid_cosine_match i_dut (.*);

	always #5ns clk = ~clk;

	// Stall the result side at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	// Check each accepted result word
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(matched, any_entry, best_id, similarity);
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_nearest_centroid_cosine_match: errors");
			$finish;
		end
	end

	function automatic logic signed [VALUE_BITS-1:0] rand_value();
		case ($urandom_range(7))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '0;
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [ID_BITS-1:0] rand_face();
		return ID_BITS'($urandom);
	endfunction

	function automatic logic [7:0] rand_entry();
		return 8'($urandom);
	endfunction

	function automatic logic [8:0] rand_element();
		return 9'($urandom);
	endfunction

	function automatic logic signed [SIM_BITS-1:0] rand_threshold();
		case ($urandom_range(3))
			0: return SIM_BITS'({$urandom, $urandom});
			1: return '0;
			default: return SIM_BITS'($urandom_range(32'h8000_0000)) - SIM_BITS'(32'h4000_0000);
		endcase
	endfunction

	// Send one input word and note it once accepted
	task automatic send_word(logic [1:0] w_op, logic [7:0] w_ent, logic [8:0] w_elem,
			logic signed [VALUE_BITS-1:0] w_val, logic [ID_BITS-1:0] w_fid);
		if ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
		end
		in_valid <= 1'b1;
		op <= w_op;
		entry <= w_ent;
		element <= w_elem;
		value <= w_val;
		face_id <= w_fid;
		do @(posedge clk); while (!in_ready);
		tracker.note_word(w_op, w_ent, w_elem, w_val, w_fid);
		case (w_op)
			ncm_pkg::OP_CEN_WR: cen_set[w_ent][w_elem] = 1'b1;
			ncm_pkg::OP_ID_WR:  id_set[w_ent] = 1'b1;
			ncm_pkg::OP_QUERY:  qry_set[w_elem] = 1'b1;
			default: ;
		endcase
	endtask

	// Hold the sender until every pending result is out, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		tracker.set_reg(idx, data);
	endtask

	task automatic configure(logic signed [SIM_BITS-1:0] thr, logic [8:0] cnt, logic [9:0] dim);
		drain();
		write_reg(ncm_pkg::CFG_THRESHOLD, thr);
		write_reg(ncm_pkg::CFG_ENTRY_COUNT, CFG_DATA_BITS'(cnt));
		write_reg(ncm_pkg::CFG_DIM_IN_USE, CFG_DATA_BITS'(dim));
		cfg_we <= 1'b0;
	endtask

	// Mix in an occasional word that cannot start a search
	task automatic maybe_noise(int dim);
		if ($urandom_range(3) != 0)
			return;
		case ($urandom_range(3))
			0: send_word(OP_UNKNOWN, rand_entry(), rand_element(), rand_value(), rand_face());
			1: begin
				send_word(ncm_pkg::OP_CEN_WR,
					$urandom_range(1) ? 8'($urandom_range(7)) : rand_entry(),
					$urandom_range(1) ? 9'($urandom_range(15)) : rand_element(),
					rand_value(), rand_face());
				scored_words++;
			end
			2: begin
				send_word(ncm_pkg::OP_ID_WR,
					$urandom_range(1) ? 8'($urandom_range(7)) : rand_entry(),
					rand_element(), rand_value(), rand_face());
				scored_words++;
			end
			default: begin
				if (dim < N_ELEM) begin
					send_word(ncm_pkg::OP_QUERY, rand_entry(),
						9'($urandom_range(N_ELEM-1, dim)), rand_value(), rand_face());
					scored_words++;
				end
			end
		endcase
	endtask

	initial begin
		int phase;
		int n_reg;
		int dim_reg;
		int n;
		int dim;
		int k;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two single-element entries at the value extremes; zero length clamps to one
		configure(THR_MIN, 9'd2, 10'd0);
		send_word(OP_UNKNOWN, rand_entry(), rand_element(), rand_value(), rand_face());
		send_word(ncm_pkg::OP_CEN_WR, 8'd0, 9'd0, VAL_MAX, rand_face());
		send_word(ncm_pkg::OP_CEN_WR, 8'd1, 9'd0, VAL_MIN, rand_face());
		send_word(ncm_pkg::OP_ID_WR, 8'd0, rand_element(), rand_value(), ID_MAX);
		send_word(ncm_pkg::OP_ID_WR, 8'd1, rand_element(), rand_value(), '0);
		send_word(ncm_pkg::OP_QUERY, rand_entry(), 9'd0, VAL_MIN, rand_face());
		send_word(ncm_pkg::OP_QUERY, rand_entry(), 9'd0, VAL_MAX, rand_face());
		// equal scores: the lower entry keeps the win
		send_word(ncm_pkg::OP_QUERY, rand_entry(), 9'd0, '0, rand_face());
		// query element past the vector length: stored, no search
		send_word(ncm_pkg::OP_QUERY, rand_entry(), 9'(N_ELEM-1), rand_value(), rand_face());
		send_word(ncm_pkg::OP_CEN_WR, 8'(N_ENT-1), 9'(N_ELEM-1), rand_value(), rand_face());
		send_word(ncm_pkg::OP_ID_WR, 8'(N_ENT-1), rand_element(), rand_value(), rand_face());

		// Empty database against the top threshold, then a threshold of minus one
		configure(THR_MAX, 9'd0, 10'd1);
		send_word(ncm_pkg::OP_QUERY, rand_entry(), 9'd0, rand_value(), rand_face());
		configure(ncm_pkg::MINUS_ONE_SCALED, 9'd0, 10'd1);
		send_word(ncm_pkg::OP_QUERY, rand_entry(), 9'd0, rand_value(), rand_face());

		// A score of exactly minus one does not beat the starting best
		configure('0, 9'd1, 10'd2);
		send_word(ncm_pkg::OP_CEN_WR, 8'd0, 9'd0, VAL_HALF, rand_face());
		send_word(ncm_pkg::OP_CEN_WR, 8'd0, 9'd1, VAL_HALF, rand_face());
		send_word(ncm_pkg::OP_QUERY, rand_entry(), 9'd0, VAL_MIN, rand_face());
		send_word(ncm_pkg::OP_QUERY, rand_entry(), 9'd1, VAL_MIN, rand_face());
		send_word(ncm_pkg::OP_QUERY, rand_entry(), 9'd0, VAL_MAX, rand_face());
		send_word(ncm_pkg::OP_QUERY, rand_entry(), 9'd1, VAL_MAX, rand_face());

		// Random phases: new registers, load what a search will read, then queries
		for (phase = 1; phase < 7 || scored_words < RANDOM_WORDS; phase++) begin
			case (phase)
				1: begin n_reg = 0; dim_reg = N_ELEM; end
				2: begin n_reg = 0; dim_reg = 1023; end
				4: begin n_reg = 2; dim_reg = 24; end
				default: begin n_reg = $urandom_range(8); dim_reg = $urandom_range(16, 1); end
			endcase
			case (phase % 4)
				0: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
				1: begin snd_idle_pct = 85; rcv_stall_pct = 0; end
				2: begin snd_idle_pct = 0; rcv_stall_pct = 85; end
				default: begin snd_idle_pct = 11; rcv_stall_pct = 11; end
			endcase
			configure(rand_threshold(), 9'(n_reg), 10'(dim_reg));
			n = tracker.search_entries();
			dim = tracker.search_dim();

			// load every cell the search will read
			for (int e = 0; e < n; e++) begin
				for (int i = 0; i < dim; i++)
					if (!cen_set[e][i])
						send_word(ncm_pkg::OP_CEN_WR, 8'(e), 9'(i), rand_value(), rand_face());
				if (!id_set[e])
					send_word(ncm_pkg::OP_ID_WR, 8'(e), rand_element(), rand_value(),
						rand_face());
			end
			if (n > 0) begin
				for (int i = 0; i < dim - 1; i++)
					if (!qry_set[i])
						send_word(ncm_pkg::OP_QUERY, rand_entry(), 9'(i), rand_value(),
							rand_face());
			end

			// update part of the query, then close it with the last element
			for (int q = 0; q < QUERIES_PER_PHASE; q++) begin
				k = $urandom_range((dim > 8) ? 8 : dim - 1);
				repeat (k) begin
					maybe_noise(dim);
					send_word(ncm_pkg::OP_QUERY, rand_entry(), 9'($urandom_range(dim - 2)),
						rand_value(), rand_face());
					scored_words++;
				end
				maybe_noise(dim);
				send_word(ncm_pkg::OP_QUERY, rand_entry(), 9'(dim - 1), rand_value(),
					rand_face());
				scored_words++;
				if ($urandom_range(7) == 0)
					drain();
			end
		end

		drain();
		if (tracker.errors == 0)
			$display("tb_nearest_centroid_cosine_match: clean");
		else
			$display("tb_nearest_centroid_cosine_match: errors");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/ncm_pkg.sv
rtl/ncm_ram.sv
rtl/ncm_search.sv
rtl/nearest_centroid_cosine_match.sv
sim/tb_nearest_centroid_cosine_match.sv
